// ===== src/spwd_pkg.sv =====
// spwd_pkg: shared types, codes and constants of the skin pixel window detector
// no dependencies; imported by spwd_cfg, spwd_front, spwd_back and the top module
package spwd_pkg;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd5;

  // register reset values
  localparam logic        RST_ENABLE    = 1'b1;
  localparam logic [10:0] RST_WIDTH     = 11'd320;
  localparam logic [10:0] RST_HEIGHT    = 11'd240;
  localparam logic [16:0] RST_THRESHOLD = 17'd600;
  localparam logic [15:0] RST_INTERVAL  = 16'd400;
  localparam logic [31:0] RST_COOLDOWN  = 32'd30000;

  // input beat kinds
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // saturation limit of the hit counter
  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  // reciprocal of five: floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x below 2^18
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  // skin test limits on 8-bit colour
  localparam logic [8:0] SKIN_R_MIN   = 9'd60;
  localparam logic [8:0] SKIN_RB_MIN  = 9'd15;
  localparam logic [8:0] SKIN_RG_MIN  = 9'd10;
  localparam logic [8:0] SKIN_R_SAT   = 9'd245;
  localparam logic [8:0] SKIN_GB_DARK = 9'd30;

  // registers seen by the back end
  typedef struct packed {
    logic        enable;
    logic [16:0] threshold;
    logic [15:0] interval;
    logic [31:0] cooldown;
  } back_cfg_t;

  // one command from the front end to the back end
  typedef struct packed {
    logic        is_start;
    logic        hit;
    logic        last;
    logic [31:0] now;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic        sampled;
    logic [16:0] count;
    logic        detected;
  } res_t;

  // warm-tone skin test on an rgb565 word
  function automatic logic is_skin(input logic [15:0] p);
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
    logic       warm;
    logic       bright;
    logic       diff;
    logic       not_red;
    r       = {1'b0, p[15:11], 3'b000};
    g       = {1'b0, p[10:5], 2'b00};
    b       = {1'b0, p[4:0], 3'b000};
    warm    = (r > g) && (g >= b);
    bright  = r > SKIN_R_MIN;
    diff    = (r > b + SKIN_RB_MIN) && (r >= g + SKIN_RG_MIN);
    not_red = (r < SKIN_R_SAT) || (g > SKIN_GB_DARK) || (b > SKIN_GB_DARK);
    return warm && bright && diff && not_red;
  endfunction

endpackage

// ===== src/spwd_fifo.sv =====
// spwd_fifo: small register queue with push/full and pop/empty
// depends on nothing; used for the command queue and the result queue
module spwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== src/spwd_cfg.sv =====
// spwd_cfg: configuration registers and precomputed window bounds
// depends on spwd_pkg
module spwd_cfg #(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [spwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data,
  output spwd_pkg::back_cfg_t                 bcfg,
  output logic [WW-1:0]                       width,
  output logic [WW-1:0]                       lo_x,
  output logic [WW-1:0]                       hi_x,
  output logic [HW-1:0]                       height,
  output logic [HW-1:0]                       lo_y,
  output logic [HW-1:0]                       hi_y
);
  import spwd_pkg::*;

  logic [10:0]   w_src;
  logic [10:0]   h_src;
  logic [WW-1:0] w_in;
  logic [HW-1:0] h_in;
  logic [HW+1:0] h_x3;
  logic          wr_width;
  logic          wr_height;

  function automatic logic [WW-1:0] clamp_w(input logic [10:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [10:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end
    return HW'(v);
  endfunction

  // floor of x / 5 by reciprocal multiply
  function automatic logic [WW-1:0] div5(input logic [WW+1:0] x);
    logic [WW+18:0] p;
    p = (WW+19)'(x) * (WW+19)'(DIV5_MUL);
    return WW'(p >> DIV5_SHIFT);
  endfunction

  // new frame size, from the reset value or the write beat
  always_comb begin
    w_src     = rst ? RST_WIDTH : cfg_data[10:0];
    h_src     = rst ? RST_HEIGHT : cfg_data[10:0];
    w_in      = clamp_w(w_src);
    h_in      = clamp_h(h_src);
    h_x3      = (HW+2)'({h_in, 1'b0}) + (HW+2)'(h_in);
    wr_width  = rst || (cfg_valid && cfg_index == CFG_WIDTH);
    wr_height = rst || (cfg_valid && cfg_index == CFG_HEIGHT);
  end

  // frame geometry: window spans 20..80 percent of width, 25..75 percent of height
  always_ff @(posedge clk) begin
    if (wr_width) begin
      width <= w_in;
      lo_x  <= div5((WW+2)'(w_in));
      hi_x  <= div5({w_in, 2'b00});
    end
    if (wr_height) begin
      height <= h_in;
      lo_y   <= HW'(h_in >> 2);
      hi_y   <= HW'(h_x3 >> 2);
    end
  end

  // gate and threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bcfg.enable    <= RST_ENABLE;
      bcfg.threshold <= RST_THRESHOLD;
      bcfg.interval  <= RST_INTERVAL;
      bcfg.cooldown  <= RST_COOLDOWN;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:    bcfg.enable    <= cfg_data[0];
        CFG_THRESHOLD: bcfg.threshold <= cfg_data[16:0];
        CFG_INTERVAL:  bcfg.interval  <= cfg_data[15:0];
        CFG_COOLDOWN:  bcfg.cooldown  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/spwd_front.sv =====
// spwd_front: accepts input beats, tracks raster position, tests window and skin colour
// depends on spwd_pkg; feeds the command queue
module spwd_front #(
  parameter int  MAX_WIDTH  = 1024,
  parameter int  MAX_HEIGHT = 1024,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 action,
  input  logic [31:0]          now_ms,
  input  logic [15:0]          pixel,
  input  logic [WW-1:0]        width,
  input  logic [WW-1:0]        lo_x,
  input  logic [WW-1:0]        hi_x,
  input  logic [HW-1:0]        height,
  input  logic [HW-1:0]        lo_y,
  input  logic [HW-1:0]        hi_y,
  output spwd_pkg::cmd_t       cmd,
  output logic                 cmd_push
);
  import spwd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic          frame_open;
  logic [CW-1:0] column;
  logic [RW-1:0] row;
  logic [WW-1:0] col_x;
  logic [WW-1:0] col_n;
  logic [HW-1:0] row_y;
  logic [HW-1:0] row_n;
  logic          in_x;
  logic          in_y;
  logic          row_end;
  logic          frame_end;
  logic          is_start;

  // position tests against the current geometry
  always_comb begin
    is_start  = action == ACT_FRAME;
    col_x     = WW'(column);
    col_n     = col_x + WW'(1);
    row_y     = HW'(row);
    row_n     = row_y + HW'(1);
    in_x      = (col_x >= lo_x) && (col_x < hi_x) && (col_x[0] == lo_x[0]);
    in_y      = (row_y >= lo_y) && (row_y < hi_y) && (row_y[0] == lo_y[0]);
    row_end   = col_n >= width;
    frame_end = row_end && (row_n >= height);
  end

  // command for the back end; pixels outside a frame are dropped here
  always_comb begin
    cmd.is_start = is_start;
    cmd.hit      = in_x && in_y && is_skin(pixel);
    cmd.last     = frame_end;
    cmd.now      = now_ms;
    cmd_push     = accept && (is_start || frame_open);
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      column     <= '0;
      row        <= '0;
    end else if (accept) begin
      if (is_start) begin
        frame_open <= 1'b1;
        column     <= '0;
        row        <= '0;
      end else if (frame_open) begin
        if (row_end) begin
          column <= '0;
          if (frame_end) begin
            frame_open <= 1'b0;
            row        <= '0;
          end else begin
            row <= RW'(row_n);
          end
        end else begin
          column <= CW'(col_n);
        end
      end
    end
  end

endmodule

// ===== src/spwd_back.sv =====
// spwd_back: time gates, hit counting, detection and result generation
// depends on spwd_pkg; drains the command queue into the result queue
module spwd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  spwd_pkg::back_cfg_t  bcfg,
  input  spwd_pkg::cmd_t       cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  logic                 res_full,
  output spwd_pkg::res_t       res,
  output logic                 res_push
);
  import spwd_pkg::*;

  logic [31:0] last_sample_time;
  logic [31:0] last_detect_time;
  logic [31:0] frame_time;
  logic        frame_sampled;
  logic [16:0] skin_total;

  logic [16:0] total_next;
  logic        is_last;
  logic        interval_ok;
  logic        cooldown_ok;
  logic        det;

  // gate tests, counter step and result
  always_comb begin
    is_last     = !cmd.is_start && cmd.last;
    cmd_pop     = !cmd_empty && (!is_last || !res_full);
    interval_ok = bcfg.enable && ((cmd.now - last_sample_time) >= {16'b0, bcfg.interval});
    cooldown_ok = (cmd.now - last_detect_time) >= bcfg.cooldown;
    total_next  = (frame_sampled && cmd.hit && skin_total != COUNT_MAX) ?
                  skin_total + 17'd1 : skin_total;
    det          = frame_sampled && (total_next >= bcfg.threshold);
    res.sampled  = frame_sampled;
    res.count    = frame_sampled ? total_next : '0;
    res.detected = det;
    res_push     = cmd_pop && is_last;
  end

  // frame state and timestamps
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time <= '0;
      last_detect_time <= '0;
      frame_time       <= '0;
      frame_sampled    <= 1'b0;
      skin_total       <= '0;
    end else if (cmd_pop) begin
      if (cmd.is_start) begin
        // interval gate moves the sample time even when the cooldown skips the frame
        if (interval_ok) begin
          last_sample_time <= cmd.now;
        end
        frame_sampled <= interval_ok && cooldown_ok;
        frame_time    <= cmd.now;
        skin_total    <= '0;
      end else begin
        skin_total <= total_next;
        if (is_last && det) begin
          last_detect_time <= frame_time;
        end
      end
    end
  end

endmodule

// ===== src/skin_pixel_window_detector.sv =====
// Skin pixel window detector: takes one input beat per clock while full is low, frame
// starts and pixels alike, so a pixel stream runs at one pixel per cycle. A front end
// tracks the raster position and tests each pixel against the central window and the
// skin colour test in the cycle it is accepted; a four-entry command queue passes the
// outcome to a back end that applies the enable, interval and cooldown gates at frame
// start, counts hits and forms the result on the last pixel. The outcome is registered
// in the command queue and the result in a two-entry result queue, where it waits;
// full rises only when both queues fill because results are not popped. Configuration
// writes are registered and always accepted.
// depends on spwd_pkg, spwd_cfg, spwd_front, spwd_fifo, spwd_back
module skin_pixel_window_detector #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            action,
  input  logic [31:0]                     now_ms,
  input  logic [15:0]                     pixel,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic                            sampled,
  output logic [16:0]                     skin_count,
  output logic                            detected,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import spwd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  back_cfg_t        bcfg;
  logic [WW-1:0]    width;
  logic [WW-1:0]    lo_x;
  logic [WW-1:0]    hi_x;
  logic [HW-1:0]    height;
  logic [HW-1:0]    lo_y;
  logic [HW-1:0]    hi_y;
  logic             accept;
  cmd_t             cmd_in;
  logic             cmd_push;
  logic [CMD_W-1:0] cmd_vec;
  cmd_t             cmd_out;
  logic             cmd_empty;
  logic             cmd_pop;
  res_t             res_in;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_vec;
  res_t             res_out;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign cmd_out   = cmd_t'(cmd_vec);
  assign res_out   = res_t'(res_vec);

  // result fields from the head of the result queue
  assign sampled    = res_out.sampled;
  assign skin_count = res_out.count;
  assign detected   = res_out.detected;

  // configuration registers
  spwd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .bcfg     (bcfg),
    .width    (width),
    .lo_x     (lo_x),
    .hi_x     (hi_x),
    .height   (height),
    .lo_y     (lo_y),
    .hi_y     (hi_y)
  );

  // front end: position and classification
  spwd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .action  (action),
    .now_ms  (now_ms),
    .pixel   (pixel),
    .width   (width),
    .lo_x    (lo_x),
    .hi_x    (hi_x),
    .height  (height),
    .lo_y    (lo_y),
    .hi_y    (hi_y),
    .cmd     (cmd_in),
    .cmd_push(cmd_push)
  );

  // command queue between front and back
  spwd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (full),
    .pop  (cmd_pop),
    .rdata(cmd_vec),
    .empty(cmd_empty)
  );

  // back end: gates, counting, detection
  spwd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .bcfg     (bcfg),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res      (res_in),
    .res_push (res_push)
  );

  // result queue
  spwd_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_vec),
    .empty(empty)
  );

endmodule

// ===== src/spwd_checker.sv =====
// spwd_checker: port-level assertions for the skin pixel window detector
// depends on skin_pixel_window_detector, to which it is bound at the end of this file
module spwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        sampled,
  input logic [16:0] skin_count,
  input logic        detected
);

  // both queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a detection only comes from a sampled frame
  a_det_sampled: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (sampled || !detected))
    else $error("detected set on an unsampled frame");

  // an unsampled frame reports no hits
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !sampled) |-> (skin_count == 17'd0))
    else $error("nonzero count on an unsampled frame");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sampled) && $stable(skin_count)
                          && $stable(detected)))
    else $error("waiting result changed before pop");

endmodule

bind skin_pixel_window_detector spwd_checker u_spwd_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .sampled   (sampled),
  .skin_count(skin_count),
  .detected  (detected)
);
